// ===== design/assert_macros.svh =====
// Concurrent assertion helpers, included by the top-level pixel generator unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent and consequent in the same cycle.
`define ASSERT_SAME_CYCLE(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent in the cycle after the antecedent.
`define ASSERT_NEXT_CYCLE(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/cpg_pkg.sv =====
package cpg_pkg;

  localparam int PIXEL_W    = 9;
  localparam int CHAN_W     = 8;
  localparam int CENTRE_W   = 16;
  localparam int RATE_W     = 10;
  localparam int TURN_W     = 32;
  localparam int LEVEL_W    = 17;
  localparam int WEIGHT_W   = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // Register stages from the input beat to the output register.
  localparam int NUM_STAGES = 13;

  localparam int DEFAULT_TEXTURE_SIZE     = 512;
  localparam int DEFAULT_SINE_TABLE_DEPTH = 1024;

  localparam logic [CENTRE_W-1:0] RESET_FIRST_U  = 16'd24904;
  localparam logic [CENTRE_W-1:0] RESET_FIRST_V  = 16'd27525;
  localparam logic [CENTRE_W-1:0] RESET_SECOND_U = 16'd43254;
  localparam logic [CENTRE_W-1:0] RESET_SECOND_V = 16'd39322;
  localparam logic [RATE_W-1:0]   RESET_CHIRP_RATE = 10'd280;

  // Radians to turns, scaled by each channel's frequency factor, Q0.32.
  localparam logic [TURN_W-1:0] TURN_RED   = 32'd683565276;
  localparam logic [TURN_W-1:0] TURN_GREEN = 32'd717743539;
  localparam logic [TURN_W-1:0] TURN_BLUE  = 32'd751921803;

  // Phase offsets with the quarter turn that makes a cosine from the sine table.
  localparam logic [TURN_W-1:0] TURN_OFS_RED   = 32'd1073741824;
  localparam logic [TURN_W-1:0] TURN_OFS_GREEN = 32'(64'd683565276 + 64'd1073741824);
  localparam logic [TURN_W-1:0] TURN_OFS_BLUE  = 32'(64'd1367130551 + 64'd1073741824);

  localparam logic [WEIGHT_W-1:0] W_RED   = 16'd13933;
  localparam logic [WEIGHT_W-1:0] W_GREEN = 16'd46872;
  localparam logic [WEIGHT_W-1:0] W_BLUE  = 16'd4732;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FIRST_CENTER_U  = 3'd0,
    REG_FIRST_CENTER_V  = 3'd1,
    REG_SECOND_CENTER_U = 3'd2,
    REG_SECOND_CENTER_V = 3'd3,
    REG_CHIRP_RATE      = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel_x;
    logic [PIXEL_W-1:0] pixel_y;
  } pixel_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] luma;
  } colour_t;

  typedef struct packed {
    logic [CENTRE_W-1:0] first_u;
    logic [CENTRE_W-1:0] first_v;
    logic [CENTRE_W-1:0] second_u;
    logic [CENTRE_W-1:0] second_v;
  } centres_t;

  typedef struct packed {
    logic [TURN_W-1:0] red;
    logic [TURN_W-1:0] green;
    logic [TURN_W-1:0] blue;
  } turns_t;

endpackage

// ===== design/cpg_pipe_ctrl.sv =====
module cpg_pipe_ctrl import cpg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  out_ready,
  output logic                  in_ready,
  output logic                  out_valid,
  output logic [NUM_STAGES-1:0] en
);

  logic [NUM_STAGES-1:0] valid;
  logic [NUM_STAGES-1:0] valid_in;

  // A stage may load when some stage at or after it is empty, or the output drains.
  always_comb begin
    for (int i = 0; i < NUM_STAGES; i++) begin
      en[i] = out_ready | ~(&(valid | ((NUM_STAGES'(1) << i) - NUM_STAGES'(1))));
    end
  end

  assign valid_in  = {valid[NUM_STAGES-2:0], in_valid};
  assign in_ready  = en[0];
  assign out_valid = valid[NUM_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      for (int i = 0; i < NUM_STAGES; i++) begin
        if (en[i]) begin
          valid[i] <= valid_in[i];
        end
      end
    end
  end

endmodule

// ===== design/cpg_texel_centre.sv =====
module cpg_texel_centre import cpg_pkg::*; #(
  parameter int TEXTURE_SIZE = DEFAULT_TEXTURE_SIZE,
  localparam int NUM_MAX = (2 * (2 ** PIXEL_W) - 1) * (2 ** CENTRE_W) + TEXTURE_SIZE,
  localparam int U_W = $clog2(NUM_MAX / (2 * TEXTURE_SIZE) + 1)
) (
  input  logic           clk,
  input  logic [1:0]     en,
  input  pixel_t         pixel,
  output logic [U_W-1:0] u,
  output logic [U_W-1:0] v
);

  localparam int NUM_W   = $clog2(NUM_MAX + 1);
  localparam int DIVISOR = 2 * TEXTURE_SIZE;
  localparam int RECIP   = (2 ** NUM_W) / DIVISOR;
  localparam int RECIP_W = $clog2(RECIP + 1);
  localparam int PROD_W  = NUM_W + RECIP_W;

  logic [NUM_W-1:0]  num_x, num_y;
  logic [PROD_W-1:0] prod_x, prod_y;
  logic [NUM_W-1:0]  num_x_a, num_y_a;
  logic [U_W-1:0]    quot_x, quot_y;
  logic [NUM_W-1:0]  rem_x, rem_y;

  // Numerator (2p+1)*65536 + SIZE, divided by 2*SIZE through a truncated
  // reciprocal; the estimate is exact or one short.
  assign num_x  = (NUM_W'({pixel.pixel_x, 1'b1}) << CENTRE_W) + NUM_W'(TEXTURE_SIZE);
  assign num_y  = (NUM_W'({pixel.pixel_y, 1'b1}) << CENTRE_W) + NUM_W'(TEXTURE_SIZE);
  assign prod_x = PROD_W'(num_x) * PROD_W'(RECIP);
  assign prod_y = PROD_W'(num_y) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      num_x_a <= num_x;
      num_y_a <= num_y;
      quot_x  <= prod_x[NUM_W +: U_W];
      quot_y  <= prod_y[NUM_W +: U_W];
    end
  end

  assign rem_x = num_x_a - NUM_W'(NUM_W'(quot_x) * NUM_W'(DIVISOR));
  assign rem_y = num_y_a - NUM_W'(NUM_W'(quot_y) * NUM_W'(DIVISOR));

  always_ff @(posedge clk) begin
    if (en[1]) begin
      u <= (rem_x >= NUM_W'(DIVISOR)) ? quot_x + U_W'(1) : quot_x;
      v <= (rem_y >= NUM_W'(DIVISOR)) ? quot_y + U_W'(1) : quot_y;
    end
  end

endmodule

// ===== design/cpg_phase.sv =====
module cpg_phase import cpg_pkg::*; #(
  parameter int U_W = CENTRE_W,
  localparam int DW = (U_W > CENTRE_W) ? U_W : CENTRE_W
) (
  input  logic              clk,
  input  logic [4:0]        en,
  input  logic [U_W-1:0]    u,
  input  logic [U_W-1:0]    v,
  input  centres_t          centres,
  input  logic [RATE_W-1:0] chirp_rate,
  output turns_t            turns
);

  localparam int SQ_W   = 2 * DW;
  localparam int DIST_W = SQ_W + 1;
  localparam int PH_W   = DIST_W + RATE_W;
  localparam int HI_W   = PH_W - TURN_W;

  logic [SQ_W-1:0]   sq1_u, sq1_v, sq2_u, sq2_v;
  logic [DIST_W-1:0] dist1, dist2;
  logic [PH_W-1:0]   phase1, phase2;
  turns_t            lo_part, hi_part;

  function automatic logic [DW-1:0] abs_diff(logic [DW-1:0] a, logic [DW-1:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  function automatic logic [SQ_W-1:0] square(logic [DW-1:0] a);
    return SQ_W'(a) * SQ_W'(a);
  endfunction

  // Upper word of the fractional part of the phase times the turn factor.
  function automatic logic [TURN_W-1:0] mul_frac(logic [TURN_W-1:0] a, logic [TURN_W-1:0] k);
    logic [2*TURN_W-1:0] p;
    p = (2*TURN_W)'(a) * (2*TURN_W)'(k);
    return p[2*TURN_W-1:TURN_W];
  endfunction

  // Whole radians times the turn factor; only the fraction of a turn matters.
  function automatic logic [TURN_W-1:0] mul_whole(logic [HI_W-1:0] h, logic [TURN_W-1:0] k);
    return TURN_W'(h) * k;
  endfunction

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sq1_u <= square(abs_diff(DW'(u), DW'(centres.first_u)));
      sq1_v <= square(abs_diff(DW'(v), DW'(centres.first_v)));
      sq2_u <= square(abs_diff(DW'(u), DW'(centres.second_u)));
      sq2_v <= square(abs_diff(DW'(v), DW'(centres.second_v)));
    end
    if (en[1]) begin
      dist1 <= DIST_W'(sq1_u) + DIST_W'(sq1_v);
      dist2 <= DIST_W'(sq2_u) + DIST_W'(sq2_v);
    end
    if (en[2]) begin
      phase1 <= PH_W'(dist1) * PH_W'(chirp_rate);
      phase2 <= PH_W'(dist2) * PH_W'(chirp_rate);
    end
    if (en[3]) begin
      lo_part.red   <= mul_frac(phase1[TURN_W-1:0], TURN_RED);
      lo_part.green <= mul_frac(phase1[TURN_W-1:0], TURN_GREEN);
      lo_part.blue  <= mul_frac(phase2[TURN_W-1:0], TURN_BLUE);
      hi_part.red   <= mul_whole(phase1[PH_W-1:TURN_W], TURN_RED);
      hi_part.green <= mul_whole(phase1[PH_W-1:TURN_W], TURN_GREEN);
      hi_part.blue  <= mul_whole(phase2[PH_W-1:TURN_W], TURN_BLUE);
    end
    if (en[4]) begin
      turns.red   <= hi_part.red + lo_part.red + TURN_OFS_RED;
      turns.green <= hi_part.green + lo_part.green + TURN_OFS_GREEN;
      turns.blue  <= hi_part.blue + lo_part.blue + TURN_OFS_BLUE;
    end
  end

endmodule

// ===== design/cpg_cos_lookup.sv =====
module cpg_cos_lookup import cpg_pkg::*; #(
  parameter int SINE_TABLE_DEPTH = DEFAULT_SINE_TABLE_DEPTH
) (
  input  logic               clk,
  input  logic [3:0]         en,
  input  logic [TURN_W-1:0]  turn,
  output logic [LEVEL_W-1:0] level
);

  localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH);
  localparam int DEP_W  = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int POS_W  = TURN_W + DEP_W;
  localparam int FRAC_W = 16;
  localparam int ACC_W  = LEVEL_W + FRAC_W + 2;
  localparam logic [63:0] ONE_Q30     = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // Table entry i holds 0.5 + 0.5 sin(2 pi i / depth) in Q1.16, built from
  // a nested polynomial on the first quadrant.
  function automatic logic [LEVEL_W-1:0] sine_entry(int unsigned i);
    logic [63:0] t, quad, r, a, a2, p, m;
    t    = (64'(i) << 32) / SINE_TABLE_DEPTH;
    quad = (t >> 30) & 64'd3;
    r    = t & (ONE_Q30 - 64'd1);
    if (quad[0]) begin
      r = ONE_Q30 - r;
    end
    a  = (r * HALF_PI_Q30) >> 30;
    a2 = (a * a) >> 30;
    p  = ONE_Q30;
    p  = ONE_Q30 - ((a2 * p) >> 30) / 156;
    p  = ONE_Q30 - ((a2 * p) >> 30) / 110;
    p  = ONE_Q30 - ((a2 * p) >> 30) / 72;
    p  = ONE_Q30 - ((a2 * p) >> 30) / 42;
    p  = ONE_Q30 - ((a2 * p) >> 30) / 20;
    p  = ONE_Q30 - ((a2 * p) >> 30) / 6;
    m  = (((a * p) >> 30) + 64'd16384) >> 15;
    if (m > 64'd32768) begin
      m = 64'd32768;
    end
    return quad[1] ? LEVEL_W'(64'd32768 - m) : LEVEL_W'(64'd32768 + m);
  endfunction

  // Two read-only tables addressed alike: the entry and its successor,
  // wrapping at the end of the turn.
  logic [LEVEL_W-1:0] rom_here [SINE_TABLE_DEPTH];
  logic [LEVEL_W-1:0] rom_succ [SINE_TABLE_DEPTH];

  for (genvar gi = 0; gi < SINE_TABLE_DEPTH; gi++) begin : g_rom
    localparam int unsigned SUCC = (gi == SINE_TABLE_DEPTH - 1) ? 0 : gi + 1;
    assign rom_here[gi] = sine_entry(gi);
    assign rom_succ[gi] = sine_entry(SUCC);
  end

  logic [POS_W-1:0]         pos;
  logic [IDX_W-1:0]         idx;
  logic [FRAC_W-1:0]        frac_a, frac_b;
  logic [LEVEL_W-1:0]       level_a, level_b, level_c;
  logic signed [LEVEL_W:0]  slope;
  logic signed [ACC_W-1:0]  step, acc;

  assign pos   = POS_W'(turn) * POS_W'(SINE_TABLE_DEPTH);
  assign slope = $signed({1'b0, level_b}) - $signed({1'b0, level_a});
  assign acc   = $signed({2'b00, level_c, FRAC_W'(0)}) + step
               + ACC_W'(signed'(33'sd32768));

  always_ff @(posedge clk) begin
    if (en[0]) begin
      idx    <= pos[TURN_W +: IDX_W];
      frac_a <= pos[TURN_W-1 -: FRAC_W];
    end
    if (en[1]) begin
      level_a <= rom_here[idx];
      level_b <= rom_succ[idx];
      frac_b  <= frac_a;
    end
    if (en[2]) begin
      step    <= ACC_W'(slope) * ACC_W'($signed({1'b0, frac_b}));
      level_c <= level_a;
    end
    if (en[3]) begin
      level <= acc[FRAC_W +: LEVEL_W];
    end
  end

endmodule

// ===== design/chirp_pattern_pixel_generator_unit.sv =====
// Two-centre chirp test pattern: each pixel beat carries a texel column and
// row, and the matching colour beat carries red, green, blue and Rec.709 luma
// bytes. One pixel is accepted per clock unless every stage is full and the
// colour side stalls; results leave in order through the register pipeline
// (texel-centre division, distance squaring, phase scaling, turn conversion,
// sine table read and interpolation, byte and luma rounding). Configuration
// registers are read as a pixel reaches the distance squaring and phase
// scaling stages, so a write also affects accepted pixels not yet there;
// write them while no pixel is in flight.
`include "assert_macros.svh"

module chirp_pattern_pixel_generator_unit import cpg_pkg::*; #(
  parameter int TEXTURE_SIZE     = DEFAULT_TEXTURE_SIZE,
  parameter int SINE_TABLE_DEPTH = DEFAULT_SINE_TABLE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   pixel_valid,
  output logic                   pixel_ready,
  input  pixel_t                 pixel,
  output logic                   colour_valid,
  input  logic                   colour_ready,
  output colour_t                colour,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int NUM_MAX = (2 * (2 ** PIXEL_W) - 1) * (2 ** CENTRE_W) + TEXTURE_SIZE;
  localparam int U_W     = $clog2(NUM_MAX / (2 * TEXTURE_SIZE) + 1);
  localparam int LP_W    = LEVEL_W + WEIGHT_W;
  localparam int SUM_W   = LP_W + 2;
  localparam int SCALE_W = SUM_W + 8;
  localparam logic [SCALE_W-1:0] LUMA_ROUND = SCALE_W'(1) << 31;

  logic [NUM_STAGES-1:0] en;
  centres_t              centres;
  logic [RATE_W-1:0]     chirp_rate;
  logic [U_W-1:0]        u, v;
  turns_t                turns;
  logic [LEVEL_W-1:0]    level_r, level_g, level_b;
  logic [CHAN_W-1:0]     byte_r, byte_g, byte_b;
  logic [LP_W-1:0]       luma_r, luma_g, luma_b;
  logic [SUM_W-1:0]      luma_sum;
  logic [SCALE_W-1:0]    luma_scaled;

  always_ff @(posedge clk) begin
    if (rst) begin
      centres.first_u  <= RESET_FIRST_U;
      centres.first_v  <= RESET_FIRST_V;
      centres.second_u <= RESET_SECOND_U;
      centres.second_v <= RESET_SECOND_V;
      chirp_rate       <= RESET_CHIRP_RATE;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FIRST_CENTER_U:  centres.first_u  <= cfg_data;
        REG_FIRST_CENTER_V:  centres.first_v  <= cfg_data;
        REG_SECOND_CENTER_U: centres.second_u <= cfg_data;
        REG_SECOND_CENTER_V: centres.second_v <= cfg_data;
        REG_CHIRP_RATE:      chirp_rate       <= cfg_data[RATE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  cpg_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pixel_valid),
    .out_ready (colour_ready),
    .in_ready  (pixel_ready),
    .out_valid (colour_valid),
    .en        (en)
  );

  cpg_texel_centre #(.TEXTURE_SIZE(TEXTURE_SIZE)) u_centre (
    .clk   (clk),
    .en    (en[1:0]),
    .pixel (pixel),
    .u     (u),
    .v     (v)
  );

  cpg_phase #(.U_W(U_W)) u_phase (
    .clk        (clk),
    .en         (en[6:2]),
    .u          (u),
    .v          (v),
    .centres    (centres),
    .chirp_rate (chirp_rate),
    .turns      (turns)
  );

  cpg_cos_lookup #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_cos_red (
    .clk   (clk),
    .en    (en[10:7]),
    .turn  (turns.red),
    .level (level_r)
  );

  cpg_cos_lookup #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_cos_green (
    .clk   (clk),
    .en    (en[10:7]),
    .turn  (turns.green),
    .level (level_g)
  );

  cpg_cos_lookup #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_cos_blue (
    .clk   (clk),
    .en    (en[10:7]),
    .turn  (turns.blue),
    .level (level_b)
  );

  // Level times 255, rounded to a byte and held at full scale.
  function automatic logic [CHAN_W-1:0] to_byte(logic [LEVEL_W-1:0] c);
    logic [LEVEL_W+7:0] s;
    s = {c, 8'd0} - (LEVEL_W+8)'(c) + (LEVEL_W+8)'(32768);
    return (s[LEVEL_W+7:16] > (LEVEL_W-8)'(255)) ? 8'hFF : s[23:16];
  endfunction

  assign luma_sum    = SUM_W'(luma_r) + SUM_W'(luma_g) + SUM_W'(luma_b);
  assign luma_scaled = (SCALE_W'(luma_sum) << 8) - SCALE_W'(luma_sum) + LUMA_ROUND;

  always_ff @(posedge clk) begin
    if (en[11]) begin
      byte_r <= to_byte(level_r);
      byte_g <= to_byte(level_g);
      byte_b <= to_byte(level_b);
      luma_r <= LP_W'(level_r) * LP_W'(W_RED);
      luma_g <= LP_W'(level_g) * LP_W'(W_GREEN);
      luma_b <= LP_W'(level_b) * LP_W'(W_BLUE);
    end
    if (en[12]) begin
      colour.red   <= byte_r;
      colour.green <= byte_g;
      colour.blue  <= byte_b;
      colour.luma  <= (luma_scaled[SCALE_W-1:32] > (SCALE_W-32)'(255)) ?
                      8'hFF : luma_scaled[39:32];
    end
  end

  `ASSERT_SAME_CYCLE(a_stall_only_when_full, clk, rst, !pixel_ready, colour_valid && !colour_ready, "pixel side stalled while the pipeline has room")
  `ASSERT_SAME_CYCLE(a_luma_near_max, clk, rst, colour_valid, ({1'b0, colour.luma} <= {1'b0, colour.red} + 9'd1) || ({1'b0, colour.luma} <= {1'b0, colour.green} + 9'd1) || ({1'b0, colour.luma} <= {1'b0, colour.blue} + 9'd1), "luma exceeds the brightest channel")
  `ASSERT_SAME_CYCLE(a_empty_after_reset, clk, rst, $past(rst), !colour_valid && pixel_ready, "pipeline not empty after reset")

endmodule
